[rtl/nes_pkg.sv]
// Shared constants for the next even 5-smooth length block.
package nes_pkg;

  // Fixed width of the requested length field.
  localparam int REQ_W = 24;

  // Default width of the length arithmetic.
  localparam int LENGTH_BITS_DEF = 24;

  // Bits handled by the shared divider in one cycle.
  localparam int DIG_W = 8;

  // Remainder width, wide enough for a divisor of 5.
  localparam int REM_W = 3;

endpackage

[rtl/nes_digit_div.sv]
// One digit of long division by 3 or by 5, shared by every division pass.
module nes_digit_div
  import nes_pkg::*;
(
  input  logic [REM_W-1:0] rem_in,
  input  logic [DIG_W-1:0] digit_in,
  input  logic             div_five,
  output logic [REM_W-1:0] rem_out,
  output logic [DIG_W-1:0] quot_digit
);

  always_comb begin
    logic [REM_W:0] part;
    logic [REM_W:0] divisor;
    logic [REM_W-1:0] rem;
    divisor    = div_five ? (REM_W+1)'(5) : (REM_W+1)'(3);
    rem        = rem_in;
    quot_digit = '0;
    // Most significant bit first; the remainder always stays below the divisor.
    for (int i = DIG_W - 1; i >= 0; i--) begin
      part = {rem, digit_in[i]};
      if (part >= divisor) begin
        part          = part - divisor;
        quot_digit[i] = 1'b1;
      end
      rem = part[REM_W-1:0];
    end
    rem_out = rem;
  end

endmodule

[rtl/next_even_5_smooth_length.sv]
// Top level: sequencer that searches for the next even 5-smooth length.
//
//  Channel   Ports                                Direction  Handshake
//  input     start, busy, in_requested_length     in         start high, busy low
//  result    out_valid, out_smooth_length         out        one-cycle strobe
//
// Requests of 2 or less answer 2 in the cycle after acceptance. Otherwise each even
// candidate gets a range check, then its factors of 2 are stripped one at a time,
// then division passes by 3 and then by 5 run, each with a check for the value 1
// and ceil((LENGTH_BITS+1)/8) digit steps of the shared divide-by-3-or-5 unit;
// the candidate count follows the gap to the next smooth number. Reset is
// synchronous and returns the sequencer to idle. The receiver cannot stall.
module next_even_5_smooth_length
  import nes_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     in_requested_length,
  output logic                 out_valid,
  output logic [LENGTH_BITS:0] out_smooth_length
);

  localparam int LEN_W  = LENGTH_BITS + 1;
  localparam int EXT_W  = (LEN_W > REQ_W) ? LEN_W : REQ_W;
  localparam int NDIG   = (LEN_W + DIG_W - 1) / DIG_W;
  localparam int V_W    = NDIG * DIG_W;
  localparam int CNT_W  = $clog2(NDIG);
  localparam logic [LENGTH_BITS:0] LIMIT = {1'b1, {LENGTH_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_STRIP2,
    S_PASS,
    S_DIV
  } state_t;

  state_t             state_r, state_nxt;
  logic [LENGTH_BITS:0] cand_r, cand_nxt;
  logic [V_W-1:0]     val_r, val_nxt;
  logic [V_W-1:0]     work_r, work_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic               div5_r, div5_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LENGTH_BITS:0] out_len_r, out_len_nxt;

  logic [EXT_W-1:0]   req_ext;
  logic [LENGTH_BITS:0] want;
  logic [REM_W-1:0]   unit_rem;
  logic [DIG_W-1:0]   unit_quot;

  // Only the low LENGTH_BITS bits of the request take part.
  assign req_ext = EXT_W'(in_requested_length);
  assign want    = {1'b0, req_ext[LENGTH_BITS-1:0]};

  nes_digit_div u_div (
    .rem_in     (rem_r),
    .digit_in   (work_r[V_W-1 -: DIG_W]),
    .div_five   (div5_r),
    .rem_out    (unit_rem),
    .quot_digit (unit_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    val_nxt       = val_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    dig_cnt_nxt   = dig_cnt_r;
    div5_nxt      = div5_r;
    out_valid_nxt = 1'b0;
    out_len_nxt   = out_len_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (want <= LEN_W'(2)) begin
            out_len_nxt   = LEN_W'(2);
            out_valid_nxt = 1'b1;
          end else begin
            cand_nxt  = want + LEN_W'(want[0]);
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (cand_r == LIMIT) begin
          out_len_nxt   = cand_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          val_nxt   = V_W'(cand_r);
          state_nxt = S_STRIP2;
        end
      end
      S_STRIP2: begin
        if (!val_r[0]) begin
          val_nxt = val_r >> 1;
        end else begin
          div5_nxt  = 1'b0;
          state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        if (val_r == V_W'(1)) begin
          out_len_nxt   = cand_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          work_nxt    = val_r;
          rem_nxt     = '0;
          dig_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        work_nxt    = {work_r[V_W-DIG_W-1:0], unit_quot};
        rem_nxt     = unit_rem;
        dig_cnt_nxt = dig_cnt_r + CNT_W'(1);
        if (dig_cnt_r == CNT_W'(NDIG - 1)) begin
          if (unit_rem == '0) begin
            // Divides evenly: keep the quotient and try the same factor again.
            val_nxt   = {work_r[V_W-DIG_W-1:0], unit_quot};
            state_nxt = S_PASS;
          end else if (!div5_r) begin
            div5_nxt  = 1'b1;
            state_nxt = S_PASS;
          end else begin
            // A factor other than 2, 3 and 5 remains: move to the next even value.
            cand_nxt  = cand_r + LEN_W'(2);
            state_nxt = S_CHECK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dig_cnt_r   <= '0;
      div5_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      div5_r      <= div5_nxt;
    end
    cand_r    <= cand_nxt;
    val_r     <= val_nxt;
    work_r    <= work_nxt;
    rem_r     <= rem_nxt;
    out_len_r <= out_len_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_smooth_length = out_len_r;

endmodule
